### design/ltl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltl_pkg: shared types and constants for the track linker
// Transaction payload structs, result kinds and field widths.
// ----------------------------------------------------------------------------
package ltl_pkg;

  localparam int TRACK_SLOTS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int POS_W   = 19;
  localparam int ID_W    = 24;
  localparam int MOL_W   = 32;
  localparam int LEN_W   = 20;
  localparam int RAD_W   = 40;
  localparam int WT_W    = 36;
  localparam int SUM_W   = 56;
  localparam logic [RAD_W-1:0] RAD_RESET = 40'd65536;
  localparam logic [LEN_W-1:0] LEN_MAX   = '1;

  typedef enum logic [2:0] {
    KIND_JOIN  = 3'd0,
    KIND_NEW   = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_FULL  = 3'd3,
    KIND_NONE  = 3'd4
  } kind_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_CULL = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [15:0]      height;
    logic [ID_W-1:0]  frame;
    logic [ID_W-1:0]  new_tag;
    logic [MOL_W-1:0] loc_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [ID_W-1:0]  trk_tag;
    logic [MOL_W-1:0] molecule_ref;
    logic [LEN_W-1:0] track_len;
    logic             last;
  } out_item_t;

endpackage

### design/localization_track_linker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// localization_track_linker: nearest-neighbour track linker
// One sequencer walks the slot table with a shared square/divide unit.
// ----------------------------------------------------------------------------
// Add finds the weight root first, then scans the slots: a free slot is skipped,
//   an open slot runs S_DX, S_DY and S_UPD, and a joined track runs two serial
//   56-bit divides (skipped if the weight total saturates or is zero), then S_EMIT.
//   Cull scans every slot. Both end in S_FIN. busy drops in the same cycle that the
//   last result appears; each result is held back one step so the final one carries
//   last. The receiver cannot stall. Synchronous rst_n empties the slot table.
module localization_track_linker #(
  parameter int TRACK_SLOTS = ltl_pkg::TRACK_SLOTS_DEF,
  parameter int FRAC_BITS   = ltl_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  ltl_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output ltl_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ltl_pkg::RAD_W-1:0] cfg_radius_sq
);

  localparam int SW   = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int QW   = ltl_pkg::SUM_W;
  localparam int QCW  = $clog2(QW + 1);
  // weight 8.8 needs sqrt(h << 2*FRAC)
  localparam int RW   = 16 + 2 * FRAC_BITS;
  localparam int SQN  = RW / 2;
  localparam int SQCW = $clog2(SQN + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQRT  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_DX    = 10'b0000001000,
    S_DY    = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_DIVX  = 10'b0001000000,
    S_DIVY  = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ltl_pkg::RAD_W-1:0] radius_r;
  ltl_pkg::in_item_t         item_r;

  // slot table (registers, addressed by the scan index, or by the free index when a track opens)
  logic [TRACK_SLOTS-1:0]    valid_r;
  logic [ltl_pkg::POS_W-1:0] cx_r   [TRACK_SLOTS];
  logic [ltl_pkg::POS_W-1:0] cy_r   [TRACK_SLOTS];
  logic [ltl_pkg::SUM_W-1:0] sx_r   [TRACK_SLOTS];
  logic [ltl_pkg::SUM_W-1:0] sy_r   [TRACK_SLOTS];
  logic [ltl_pkg::WT_W-1:0]  wt_r   [TRACK_SLOTS];
  logic [ltl_pkg::ID_W-1:0]  fr_r   [TRACK_SLOTS];
  logic [ltl_pkg::LEN_W-1:0] len_r  [TRACK_SLOTS];
  logic [ltl_pkg::ID_W-1:0]  tid_r  [TRACK_SLOTS];

  logic [SW:0]               slot_r;
  logic [RW-1:0]             w_r;
  logic [RW-1:0]             srem_r;
  logic [RW+1:0]             sacc_r;
  logic [SQCW-1:0]           scnt_r;
  logic [ltl_pkg::RAD_W:0]   sqd_r;
  logic [QW-1:0]             num_r;
  logic [QW-1:0]             quo_r;
  logic [ltl_pkg::WT_W:0]    rem_r;
  logic [QCW-1:0]            dcnt_r;
  logic                      out_valid_r;
  ltl_pkg::out_item_t        out_r;
  logic                      hold_v_r;
  ltl_pkg::out_item_t        hold_r;

  logic [SW-1:0] si;
  logic          scan_end;
  assign si       = slot_r[SW-1:0];
  assign scan_end = (slot_r == (SW+1)'(TRACK_SLOTS));

  // shared unit operands: one square, one restoring step
  logic [ltl_pkg::POS_W-1:0] sq_a, sq_b, sq_d;
  logic [2*ltl_pkg::POS_W-1:0] sq_p;
  assign sq_d = (sq_a > sq_b) ? sq_a - sq_b : sq_b - sq_a;
  assign sq_p = sq_d * sq_d;

  logic [ltl_pkg::WT_W:0]   rsh;
  logic [ltl_pkg::WT_W-1:0] dv;
  logic                     qbit;
  assign dv   = wt_r[si];
  assign rsh  = {rem_r[ltl_pkg::WT_W-1:0], num_r[QW-1]};
  assign qbit = (rsh >= {1'b0, dv});

  // sqrt step: two bits per cycle, classic digit recurrence
  logic [RW+1:0] s_trial, s_rem_sh;
  assign s_rem_sh = {sacc_r[RW-1:0], srem_r[RW-1 -: 2]};
  assign s_trial  = {w_r, 2'b01};

  logic                          match;
  logic [ltl_pkg::WT_W:0]        wt_sum;
  logic [SQN+ltl_pkg::POS_W-1:0] wpx_p, wpy_p;
  logic [ltl_pkg::SUM_W-1:0]     wpx, wpy;
  assign match  = (sqd_r < {1'b0, radius_r});
  assign wt_sum = {1'b0, wt_r[si]} + (ltl_pkg::WT_W+1)'(w_r[SQN-1:0]);
  assign wpx_p  = w_r[SQN-1:0] * item_r.pos_x;
  assign wpy_p  = w_r[SQN-1:0] * item_r.pos_y;
  assign wpx    = (ltl_pkg::SUM_W)'(wpx_p);
  assign wpy    = (ltl_pkg::SUM_W)'(wpy_p);

  // lowest free slot
  logic [SW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    sq_a = cx_r[si];
    sq_b = item_r.pos_x;
    if (state_r == S_DY) begin
      sq_a = cy_r[si];
      sq_b = item_r.pos_y;
    end
  end

  // result produced by this step; it waits in the hold register
  logic               res_new;
  ltl_pkg::out_item_t res_item;
  always_comb begin
    res_new  = 1'b0;
    res_item = '0;
    case (state_r)
      S_SCAN: begin
        if (!scan_end && item_r.operation == ltl_pkg::OP_CULL && valid_r[si] &&
            fr_r[si] < item_r.frame) begin
          res_new  = 1'b1;
          res_item = '{ltl_pkg::KIND_CLOSE, tid_r[si], '0, len_r[si], 1'b0};
        end
      end
      S_EMIT: begin
        res_new  = 1'b1;
        res_item = '{ltl_pkg::KIND_JOIN, tid_r[si], item_r.loc_index, len_r[si], 1'b0};
      end
      default: ;
    endcase
  end

  // release the held result, or the closing result at the end of the walk
  logic               out_fire;
  ltl_pkg::out_item_t out_nxt;
  assign out_fire = (res_new && hold_v_r) || (state_r == S_FIN);
  always_comb begin
    out_nxt = hold_r;
    if (state_r == S_FIN) begin
      if (hold_v_r) begin
        out_nxt.last = 1'b1;
      end else if (item_r.operation == ltl_pkg::OP_CULL) begin
        out_nxt = '{ltl_pkg::KIND_NONE, '0, '0, '0, 1'b1};
      end else if (!free_ok) begin
        out_nxt = '{ltl_pkg::KIND_FULL, item_r.new_tag, item_r.loc_index, '0, 1'b1};
      end else begin
        out_nxt = '{ltl_pkg::KIND_NEW, item_r.new_tag, item_r.loc_index,
                    (ltl_pkg::LEN_W)'(1), 1'b1};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (in_item.operation == ltl_pkg::OP_ADD) ? S_SQRT : S_SCAN;
      end
      S_SQRT: if (scnt_r == SQCW'(SQN - 1)) state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) state_nxt = S_FIN;
        else if (item_r.operation == ltl_pkg::OP_ADD && valid_r[si]) state_nxt = S_DX;
      end
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_UPD;
      S_UPD: begin
        if (!match) state_nxt = S_SCAN;
        else if (wt_sum[ltl_pkg::WT_W] || wt_sum == '0) state_nxt = S_EMIT;
        else state_nxt = S_DIVX;
      end
      S_DIVX: if (dcnt_r == QCW'(QW - 1)) state_nxt = S_DIVY;
      S_DIVY: if (dcnt_r == QCW'(QW - 1)) state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_SCAN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      radius_r    <= ltl_pkg::RAD_RESET;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_fire;
      if (out_fire) out_r <= out_nxt;
      if (state_r == S_FIN) begin
        hold_v_r <= 1'b0;
      end else if (res_new) begin
        hold_v_r <= 1'b1;
        hold_r   <= res_item;
      end
      case (state_r)
        // latch the radius on cfg_valid; on start take the transaction, clear the sqrt accumulators
        S_IDLE: begin
          if (cfg_valid) radius_r <= cfg_radius_sq;
          if (start) begin
            item_r <= in_item;
            slot_r <= '0;
            w_r    <= '0;
            sacc_r <= '0;
            srem_r <= RW'(in_item.height) << (2 * FRAC_BITS);
            scnt_r <= '0;
          end
        end
        // advance the root one bit, consuming two radicand bits
        S_SQRT: begin
          srem_r <= srem_r << 2;
          scnt_r <= scnt_r + 1'b1;
          if (s_rem_sh >= s_trial) begin
            sacc_r <= s_rem_sh - s_trial;
            w_r    <= {w_r[RW-2:0], 1'b1};
          end else begin
            sacc_r <= s_rem_sh;
            w_r    <= {w_r[RW-2:0], 1'b0};
          end
        end
        // walk the slots
        S_SCAN: begin
          if (!scan_end) begin
            if (item_r.operation == ltl_pkg::OP_ADD) begin
              if (!valid_r[si]) slot_r <= slot_r + 1'b1;
            end else begin
              if (valid_r[si] && fr_r[si] < item_r.frame) valid_r[si] <= 1'b0;
              slot_r <= slot_r + 1'b1;
            end
          end
        end
        S_DX: sqd_r <= (ltl_pkg::RAD_W+1)'(sq_p);
        S_DY: sqd_r <= sqd_r + (ltl_pkg::RAD_W+1)'(sq_p);
        // update a matched slot or move on
        S_UPD: begin
          if (!match) begin
            slot_r <= slot_r + 1'b1;
          end else begin
            fr_r[si] <= item_r.frame;
            if (len_r[si] != ltl_pkg::LEN_MAX) len_r[si] <= len_r[si] + 1'b1;
            if (!wt_sum[ltl_pkg::WT_W]) begin
              sx_r[si] <= sx_r[si] + wpx;
              sy_r[si] <= sy_r[si] + wpy;
              wt_r[si] <= wt_sum[ltl_pkg::WT_W-1:0];
              if (wt_sum == '0) begin
                cx_r[si] <= item_r.pos_x;
                cy_r[si] <= item_r.pos_y;
              end else begin
                num_r  <= sx_r[si] + wpx + (ltl_pkg::SUM_W)'(wt_sum[ltl_pkg::WT_W-1:1]);
                rem_r  <= '0;
                dcnt_r <= '0;
              end
            end
          end
        end
        // one quotient bit a cycle
        S_DIVX, S_DIVY: begin
          quo_r <= {quo_r[QW-2:0], qbit};
          if (dcnt_r == QCW'(QW - 1)) begin
            if (state_r == S_DIVX) begin
              cx_r[si] <= {quo_r[ltl_pkg::POS_W-2:0], qbit};
              num_r    <= sy_r[si] + (ltl_pkg::SUM_W)'(dv[ltl_pkg::WT_W-1:1]);
              rem_r    <= '0;
              dcnt_r   <= '0;
            end else begin
              cy_r[si] <= {quo_r[ltl_pkg::POS_W-2:0], qbit};
            end
          end else begin
            num_r  <= num_r << 1;
            dcnt_r <= dcnt_r + 1'b1;
            rem_r  <= qbit ? rsh - {1'b0, dv} : rsh;
          end
        end
        // report the join, move to the next slot
        S_EMIT: slot_r <= slot_r + 1'b1;
        // open a new track when nothing joined
        S_FIN: begin
          if (!hold_v_r && item_r.operation == ltl_pkg::OP_ADD && free_ok) begin
            valid_r[free_idx] <= 1'b1;
            sx_r[free_idx]  <= wpx;
            sy_r[free_idx]  <= wpy;
            wt_r[free_idx]  <= (ltl_pkg::WT_W)'(w_r[SQN-1:0]);
            cx_r[free_idx]  <= item_r.pos_x;
            cy_r[free_idx]  <= item_r.pos_y;
            fr_r[free_idx]  <= item_r.frame;
            len_r[free_idx] <= (ltl_pkg::LEN_W)'(1);
            tid_r[free_idx] <= item_r.new_tag;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
